@@ rtl/core/opmt_pkg.sv @@
// Package of types, codes and constants for the millisecond interval timer.
`default_nettype none

package opmt_pkg;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ARM   = 2'd1,
		OP_READ  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	// Result status codes
	localparam logic ST_OK          = 1'b0;
	localparam logic ST_NOT_EXPIRED = 1'b1;

	localparam logic [9:0]  MS_PER_SEC = 10'd1000;
	localparam logic [19:0] NS_PER_MS  = 20'd1000000;

	// Reciprocal of 1e6 scaled by 2^50: exact floor for any 30-bit numerator
	localparam int unsigned NS_SHIFT = 50;
	localparam logic [30:0] NS_RECIP =
		31'(((64'd1 << NS_SHIFT) + 64'(NS_PER_MS) - 64'd1) / 64'(NS_PER_MS));

	// Reciprocal of 1000 scaled by 2^52: exact floor for any 42-bit numerator
	localparam int unsigned MS_SHIFT = 52;
	localparam logic [42:0] MS_RECIP =
		43'(((64'd1 << MS_SHIFT) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));

	// Millisecond counts at or above this overflow a 32-bit seconds field
	localparam logic [63:0] SPLIT_LIMIT_MS = 64'(MS_PER_SEC) << 32;
	localparam logic [31:0] SAT_SEC        = 32'hFFFF_FFFF;
	localparam logic [29:0] SAT_NSEC       = 30'd999000000;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] value_sec;
		logic [29:0] value_nsec;
		logic [31:0] period_sec;
		logic [29:0] period_nsec;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic        expirations;
		logic [31:0] remaining_sec;
		logic [29:0] remaining_nsec;
		logic [31:0] reload_sec;
		logic [29:0] reload_nsec;
	} rsp_t;

	// Seconds plus nanoseconds to whole milliseconds, 42 bits
	function automatic logic [41:0] to_ms(input logic [31:0] sec, input logic [29:0] nsec);
		logic [41:0] sec_ms;
		logic [60:0] prod;
		sec_ms = 42'(sec) * 42'(MS_PER_SEC);
		prod   = 61'(nsec) * 61'(NS_RECIP);
		return sec_ms + 42'(prod[60:NS_SHIFT]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/opmt_chan_if.sv @@
// Valid/ready channel interface carrying one item of a given type.
`default_nettype none

interface opmt_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/oneshot_periodic_ms_timer_top.sv @@
// Top level of the millisecond interval timer: state update and result pipeline.
//
//  channel | dir | payload        | accepted when
//  --------+-----+----------------+------------------------
//  cmd     | in  | opmt_pkg::cmd_t| cmd.valid & cmd.ready
//  rsp     | out | opmt_pkg::rsp_t| rsp.valid & rsp.ready
//
// One item accepted per cycle while no result waits on rsp; each item gives one result.
// The timer state updates in stage 2 -> 3; stages 3 to 7 split the reported
// millisecond counts into seconds and nanoseconds (reciprocal multiply in
// partial products, remainder, scale). The whole pipeline moves as one and
// holds while a result waits on rsp. arst_n clears the timer state and all
// valid flags.
`default_nettype none

module oneshot_periodic_ms_timer_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	opmt_chan_if.sink      cmd,
	opmt_chan_if.source    rsp
);

	typedef struct packed {
		logic rep;
		logic status;
		logic expir;
	} ctl_t;

	logic adv;

	// Stage 1: item register
	logic           v_s1;
	opmt_pkg::cmd_t cmd_s1;

	// Stage 2: converted times
	logic          v_s2;
	opmt_pkg::op_t op_s2;
	logic [41:0]   delay_s2;
	logic [41:0]   ivl_s2;

	// Timer state
	logic [63:0] now_q;
	logic [63:0] expiry_q;
	logic [41:0] interval_q;

	// Stage 3: snapshot of reported times
	logic        v_s3;
	ctl_t        ctl_s3;
	logic [63:0] rem_s3;
	logic [41:0] ivl_s3;

	// Stages 4 to 6, lane 0 remaining time, lane 1 interval
	logic        v_s4, v_s5, v_s6;
	ctl_t        ctl_s4, ctl_s5, ctl_s6;
	logic [42:0] pp_hh_s4 [2];
	logic [42:0] pp_hl_s4 [2];
	logic [42:0] pp_lh_s4 [2];
	logic [42:0] pp_ll_s4 [2];
	logic [9:0]  xlo_s4 [2];
	logic        sat_s4 [2];
	logic [31:0] q_s5 [2];
	logic [9:0]  xlo_s5 [2];
	logic        sat_s5 [2];
	logic [31:0] q_s6 [2];
	logic [9:0]  r_s6 [2];
	logic        sat_s6 [2];

	// Output register
	logic           out_v_q;
	opmt_pkg::rsp_t out_q;

	// Pipeline moves when the output slot is free or being taken
	assign adv       = !out_v_q || rsp.ready;
	assign cmd.ready = adv;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= cmd.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			out_v_q <= v_s6;
		end
	end

	// Stage 1 and 2: register item, convert to milliseconds
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= cmd.data;
			op_s2    <= cmd_s1.opcode;
			delay_s2 <= opmt_pkg::to_ms(cmd_s1.value_sec, cmd_s1.value_nsec);
			ivl_s2   <= opmt_pkg::to_ms(cmd_s1.period_sec, cmd_s1.period_nsec);
		end
	end

	// Remaining time and due check against current state
	logic [64:0] diff;
	logic [63:0] rem;
	logic        due;
	assign diff = {1'b0, expiry_q} - {1'b0, now_q};
	assign rem  = diff[64] ? 64'd0 : diff[63:0];
	assign due  = (expiry_q != 64'd0) && (now_q >= expiry_q);

	// Timer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= 64'd0;
			expiry_q   <= 64'd0;
			interval_q <= 42'd0;
		end else if (adv && v_s2) begin
			case (op_s2)
				opmt_pkg::OP_TICK: begin
					now_q <= now_q + 64'd1;
				end
				opmt_pkg::OP_ARM: begin
					interval_q <= ivl_s2;
					expiry_q   <= (delay_s2 != 42'd0) ? now_q + 64'(delay_s2) : 64'd0;
				end
				opmt_pkg::OP_READ: begin
					if (due) begin
						expiry_q <= (interval_q != 42'd0) ?
							expiry_q + 64'(interval_q) : 64'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 3: result kind and pre-update snapshot
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3.rep    <= (op_s2 == opmt_pkg::OP_ARM) || (op_s2 == opmt_pkg::OP_QUERY);
			ctl_s3.status <= (op_s2 == opmt_pkg::OP_READ && !due) ?
				opmt_pkg::ST_NOT_EXPIRED : opmt_pkg::ST_OK;
			ctl_s3.expir  <= (op_s2 == opmt_pkg::OP_READ) && due;
			rem_s3        <= rem;
			ivl_s3        <= interval_q;
		end
	end

	// Stage 3 to 4: saturation check and reciprocal partial products
	logic [63:0] lane_in [2];
	logic [41:0] lane_x [2];
	assign lane_in[0] = rem_s3;
	assign lane_in[1] = 64'(ivl_s3);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			lane_x[l] = lane_in[l][41:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			for (int l = 0; l < 2; l++) begin
				sat_s4[l]   <= lane_in[l] >= opmt_pkg::SPLIT_LIMIT_MS;
				xlo_s4[l]   <= lane_x[l][9:0];
				pp_hh_s4[l] <= 43'(lane_x[l][41:21]) * 43'(opmt_pkg::MS_RECIP[42:21]);
				pp_hl_s4[l] <= 43'(lane_x[l][41:21]) * 43'(opmt_pkg::MS_RECIP[20:0]);
				pp_lh_s4[l] <= 43'(lane_x[l][20:0]) * 43'(opmt_pkg::MS_RECIP[42:21]);
				pp_ll_s4[l] <= 43'(lane_x[l][20:0]) * 43'(opmt_pkg::MS_RECIP[20:0]);
			end
		end
	end

	// Stage 4 to 5: sum partial products, quotient by 1000
	logic [84:0] psum [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			psum[l] = (85'(pp_hh_s4[l]) << 42)
				+ ((85'(pp_hl_s4[l]) + 85'(pp_lh_s4[l])) << 21)
				+ 85'(pp_ll_s4[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5 <= ctl_s4;
			for (int l = 0; l < 2; l++) begin
				q_s5[l]   <= psum[l][opmt_pkg::MS_SHIFT+31:opmt_pkg::MS_SHIFT];
				xlo_s5[l] <= xlo_s4[l];
				sat_s5[l] <= sat_s4[l];
			end
		end
	end

	// Stage 5 to 6: remainder; below 1024 so the low ten bits suffice
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
			for (int l = 0; l < 2; l++) begin
				q_s6[l]   <= q_s5[l];
				r_s6[l]   <= xlo_s5[l] - 10'(q_s5[l][9:0] * opmt_pkg::MS_PER_SEC);
				sat_s6[l] <= sat_s5[l];
			end
		end
	end

	// Stage 6 to output: scale remainder, saturate, select by result kind
	logic [31:0] sec_o [2];
	logic [29:0] nsec_o [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (!ctl_s6.rep) begin
				sec_o[l]  = 32'd0;
				nsec_o[l] = 30'd0;
			end else if (sat_s6[l]) begin
				sec_o[l]  = opmt_pkg::SAT_SEC;
				nsec_o[l] = opmt_pkg::SAT_NSEC;
			end else begin
				sec_o[l]  = q_s6[l];
				nsec_o[l] = 30'(r_s6[l] * 30'(opmt_pkg::NS_PER_MS));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.status         <= ctl_s6.status;
			out_q.expirations    <= ctl_s6.expir;
			out_q.remaining_sec  <= sec_o[0];
			out_q.remaining_nsec <= nsec_o[0];
			out_q.reload_sec     <= sec_o[1];
			out_q.reload_nsec    <= nsec_o[1];
		end
	end

endmodule

`default_nettype wire

@@ test/tb_oneshot_periodic_ms_timer_top.sv @@
// Testbench for the millisecond interval timer: directed cases, random traffic, stall checks.
`timescale 1ns / 100ps

module tb_oneshot_periodic_ms_timer_top;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	opmt_chan_if #(.item_t(opmt_pkg::cmd_t)) cmd_ch ();
	opmt_chan_if #(.item_t(opmt_pkg::rsp_t)) rsp_ch ();

	oneshot_periodic_ms_timer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Timer state mirrored by the predictor
	logic [63:0] clock_ms;
	logic [63:0] expiry_at;
	logic [41:0] reload_ms;

	opmt_pkg::rsp_t pending_rsp[$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count = 0;
	int   results_seen = 0;
	int   cycle_count = 0;
	logic hold_active = 1'b0;
	event hold_off_ev;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Seconds plus nanoseconds to whole milliseconds, kept to 42 bits
	function automatic logic [41:0] span_to_ms(input logic [31:0] sec, input logic [29:0] nsec);
		logic [63:0] total;
		total = 64'(sec) * 64'(opmt_pkg::MS_PER_SEC) + 64'(nsec) / 64'(opmt_pkg::NS_PER_MS);
		return total[41:0];
	endfunction

	// Milliseconds to seconds plus nanoseconds, saturating past 32-bit seconds
	function automatic void split_span(input logic [63:0] ms, output logic [31:0] sec,
			output logic [29:0] nsec);
		logic [63:0] whole;
		whole = ms / 64'(opmt_pkg::MS_PER_SEC);
		if (whole > 64'hFFFF_FFFF) begin
			sec  = opmt_pkg::SAT_SEC;
			nsec = opmt_pkg::SAT_NSEC;
		end else begin
			sec  = whole[31:0];
			nsec = 30'((ms % 64'(opmt_pkg::MS_PER_SEC)) * 64'(opmt_pkg::NS_PER_MS));
		end
	endfunction

	function automatic void fill_times(inout opmt_pkg::rsp_t r);
		logic [63:0] left;
		left = (expiry_at > clock_ms) ? expiry_at - clock_ms : 64'd0;
		split_span(left, r.remaining_sec, r.remaining_nsec);
		split_span(64'(reload_ms), r.reload_sec, r.reload_nsec);
	endfunction

	// Apply one accepted item to the mirrored state and return its result
	function automatic opmt_pkg::rsp_t advance_timer(input opmt_pkg::cmd_t c);
		opmt_pkg::rsp_t r;
		logic [41:0] delay;
		r = '0;
		case (c.opcode)
			opmt_pkg::OP_TICK: begin
				clock_ms = clock_ms + 64'd1;
			end
			opmt_pkg::OP_ARM: begin
				fill_times(r);
				delay     = span_to_ms(c.value_sec, c.value_nsec);
				reload_ms = span_to_ms(c.period_sec, c.period_nsec);
				expiry_at = (delay != 0) ? clock_ms + 64'(delay) : 64'd0;
			end
			opmt_pkg::OP_READ: begin
				if (expiry_at != 0 && clock_ms >= expiry_at) begin
					r.expirations = 1'b1;
					expiry_at = (reload_ms != 0) ? expiry_at + 64'(reload_ms) : 64'd0;
				end else begin
					r.status = opmt_pkg::ST_NOT_EXPIRED;
				end
			end
			default: begin
				fill_times(r);
			end
		endcase
		return r;
	endfunction

	function automatic opmt_pkg::cmd_t make_cmd(input opmt_pkg::op_t op,
			input logic [31:0] vs, input logic [29:0] vn,
			input logic [31:0] ps, input logic [29:0] pn);
		opmt_pkg::cmd_t c;
		c.opcode      = op;
		c.value_sec   = vs;
		c.value_nsec  = vn;
		c.period_sec  = ps;
		c.period_nsec = pn;
		return c;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// Offer one item from a falling edge; return at the falling edge after acceptance
	task automatic send_cmd(input opmt_pkg::cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(advance_timer(c));
		@(negedge clk);
	endtask

	// Item of the given opcode with random content in every other field
	task automatic send_filler(input opmt_pkg::op_t op);
		send_cmd(make_cmd(op, $urandom, 30'($urandom), $urandom, 30'($urandom)));
	endtask

	task automatic send_arm(input logic [31:0] vs, input logic [29:0] vn,
			input logic [31:0] ps, input logic [29:0] pn);
		send_cmd(make_cmd(opmt_pkg::OP_ARM, vs, vn, ps, pn));
	endtask

	// Arm with a delay of up to 12 ms (plus one second at times) and an interval of 1 to 8 ms or none, so reads can fire
	task automatic arm_short();
		logic [29:0] pn;
		pn = ($urandom_range(0, 99) < 20) ? 30'd0 : 30'($urandom_range(1000000, 8999999));
		send_arm(($urandom_range(0, 99) < 3) ? 32'd1 : 32'd0,
			30'($urandom_range(0, 12000000)), 32'd0, pn);
	endtask

	// Arm followed by a random run of ticks, reads, queries and re-arms
	task automatic run_timer_scenario();
		int steps;
		int roll;
		arm_short();
		steps = $urandom_range(8, 40);
		repeat (steps) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				send_filler(opmt_pkg::OP_TICK);
			else if (roll < 80)
				send_filler(opmt_pkg::OP_READ);
			else if (roll < 92)
				send_filler(opmt_pkg::OP_QUERY);
			else
				arm_short();
		end
	endtask

	// Idle state: nothing armed, clock at zero
	task automatic test_reset_state();
		send_filler(opmt_pkg::OP_QUERY);
		send_filler(opmt_pkg::OP_READ);
		send_filler(opmt_pkg::OP_TICK);
		send_filler(opmt_pkg::OP_QUERY);
	endtask

	// Periodic timer: fire, reload by the interval, fire again
	task automatic test_periodic_reload();
		send_arm(32'd0, 30'd3000000, 32'd0, 30'd2500000);
		send_filler(opmt_pkg::OP_QUERY);
		send_filler(opmt_pkg::OP_READ);
		repeat (3) send_filler(opmt_pkg::OP_TICK);
		send_filler(opmt_pkg::OP_READ);
		send_filler(opmt_pkg::OP_READ);
		repeat (2) send_filler(opmt_pkg::OP_TICK);
		send_filler(opmt_pkg::OP_READ);
	endtask

	// One-shot timer disarms after firing; zero delay disarms at once
	task automatic test_one_shot_and_disarm();
		send_arm(32'd0, 30'd999999, 32'd0, 30'd0);
		send_filler(opmt_pkg::OP_READ);
		send_arm(32'd0, 30'd1000000, 32'd0, 30'd0);
		send_filler(opmt_pkg::OP_TICK);
		send_filler(opmt_pkg::OP_READ);
		send_filler(opmt_pkg::OP_READ);
		send_arm(32'd0, 30'd0, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
		send_filler(opmt_pkg::OP_QUERY);
		send_filler(opmt_pkg::OP_READ);
	endtask

	// Saturated seconds, nanoseconds past one second, largest fields
	task automatic test_saturation();
		send_arm(32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0, 30'd1000000);
		send_filler(opmt_pkg::OP_QUERY);
		send_arm(32'hFFFF_FFFF, 30'd999999999, 32'd1, 30'd999999999);
		send_filler(opmt_pkg::OP_QUERY);
		send_arm(32'd0, 30'h3FFF_FFFF, 32'd0, 30'h3FFF_FFFF);
		send_filler(opmt_pkg::OP_QUERY);
	endtask

	// Mostly well-formed timer sequences, with bursts of random items between
	task automatic test_random_mix(input int send_pct, input int recv_pct, input int count);
		int sent_at_start;
		sent_at_start = results_seen + pending_rsp.size();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (results_seen + pending_rsp.size() - sent_at_start < count) begin
			if ($urandom_range(0, 99) < 80)
				run_timer_scenario();
			else
				repeat ($urandom_range(1, 4))
					send_filler(opmt_pkg::op_t'($urandom_range(0, 3)));
		end
	endtask

	// Receiver holds off for a long stretch while items keep coming
	task automatic test_input_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> hold_off_ev;
		run_timer_scenario();
		run_timer_scenario();
	endtask

	// Receiver ready, with random gaps and the long hold-off
	always @(negedge clk) begin
		if (hold_active)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		forever begin
			@(hold_off_ev);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_active = 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		opmt_pkg::rsp_t want;
		opmt_pkg::rsp_t got;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				report_error("result arrived with none expected");
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status)
					report_error($sformatf("result %0d status: got %0d, want %0d",
						results_seen, got.status, want.status));
				if (got.expirations !== want.expirations)
					report_error($sformatf("result %0d expirations: got %0d, want %0d",
						results_seen, got.expirations, want.expirations));
				if (got.remaining_sec !== want.remaining_sec)
					report_error($sformatf("result %0d remaining_sec: got %0d, want %0d",
						results_seen, got.remaining_sec, want.remaining_sec));
				if (got.remaining_nsec !== want.remaining_nsec)
					report_error($sformatf("result %0d remaining_nsec: got %0d, want %0d",
						results_seen, got.remaining_nsec, want.remaining_nsec));
				if (got.reload_sec !== want.reload_sec)
					report_error($sformatf("result %0d reload_sec: got %0d, want %0d",
						results_seen, got.reload_sec, want.reload_sec));
				if (got.reload_nsec !== want.reload_nsec)
					report_error($sformatf("result %0d reload_nsec: got %0d, want %0d",
						results_seen, got.reload_nsec, want.reload_nsec));
			end
			results_seen++;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_rsp.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		clock_ms     = '0;
		expiry_at    = '0;
		reload_ms    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 0;
		recv_idle_pct = 30;
		test_reset_state();
		test_periodic_reload();
		test_one_shot_and_disarm();
		test_saturation();
		test_random_mix(6, 71, PHASE_ITEMS);
		test_random_mix(71, 6, PHASE_ITEMS);
		test_random_mix(0, 0, PHASE_ITEMS);
		test_input_stall();
		cmd_ch.valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/opmt_pkg.sv
rtl/core/opmt_chan_if.sv
rtl/core/oneshot_periodic_ms_timer_top.sv
test/tb_oneshot_periodic_ms_timer_top.sv
